// ----- rtl/baro_temp_pressure_compensate_macros.svh -----
// Assertion macros for the barometer compensation block.
// Used by the top level only; no other dependencies.
`ifndef BARO_TEMP_PRESSURE_COMPENSATE_MACROS_SVH
`define BARO_TEMP_PRESSURE_COMPENSATE_MACROS_SVH

// Condition must hold at every edge outside reset.
`define BTPC_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("btpc assertion failed");

// Consequent must hold in the same cycle as the antecedent.
`define BTPC_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("btpc assertion failed");

`endif

// ----- rtl/btpc_pkg.sv -----
// Shared types, constants and helper functions for the barometer compensation block.
// No dependencies.
package btpc_pkg;

   localparam int DivSteps = 32;
   localparam int DivSideW = 53;

   localparam logic signed [31:0] B6Offset  = 32'sd4000;
   localparam logic signed [31:0] QuadCoef  = 32'sd3038;
   localparam logic signed [31:0] LinCoef   = -32'sd7357;
   localparam logic signed [31:0] FinalOffs = 32'sd3791;
   localparam logic [31:0]        B4Offset  = 32'd32768;
   localparam logic [31:0]        B7Scale   = 32'd50000;
   localparam logic signed [31:0] TempMax   = 32'sd32767;
   localparam logic signed [31:0] TempMin   = -32'sd32768;

   typedef enum logic [2:0] {
      CSR_AC1     = 3'd0,
      CSR_AC2     = 3'd1,
      CSR_AC3     = 3'd2,
      CSR_AC4_AC5 = 3'd3,
      CSR_AC6     = 3'd4,
      CSR_B1_B2   = 3'd5,
      CSR_MC_MD   = 3'd6,
      CSR_OSS     = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [15:0] raw_temp;
      logic [18:0] raw_pressure;
   } req_type;

   typedef struct packed {
      logic signed [15:0] temp_tenths_c;
      logic signed [31:0] pressure_pa;
      logic               div_error;
   } rsp_type;

   typedef struct packed {
      logic [15:0] ac1;
      logic [15:0] ac2;
      logic [15:0] ac3;
      logic [15:0] ac4;
      logic [15:0] ac5;
      logic [15:0] ac6;
      logic [15:0] b1;
      logic [15:0] b2;
      logic [15:0] mc;
      logic [15:0] md;
      logic [1:0]  oss;
   } cfg_type;

   // sideband through the temperature divider
   typedef struct packed {
      logic signed [31:0] x1;
      logic [18:0]        rp;
      logic               dz;
      logic               neg;
   } div1_side_type;

   // sideband through the pressure divider
   typedef struct packed {
      logic               dz;
      logic               b4z;
      logic               big;
      logic signed [15:0] t;
   } div2_side_type;

   function automatic logic signed [31:0] sext16(input logic [15:0] v);
      return {{16{v[15]}}, v};
   endfunction

   // signed division by 2^k, truncating toward zero
   function automatic logic signed [31:0] sdiv_pow2(input logic signed [31:0] v,
                                                    input int unsigned k);
      logic signed [31:0] bias;
      bias = v[31] ? signed'(32'((33'd1 << k) - 33'd1)) : 32'sd0;
      return (v + bias) >>> k;
   endfunction

endpackage

// ----- rtl/btpc_udiv.sv -----
// Pipelined unsigned 32/32 restoring divider, one quotient bit per stage.
// Depends on btpc_pkg (step count, sideband width).
module btpc_udiv (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          adv,
   input  logic                          in_valid,
   input  logic [31:0]                   in_dividend,
   input  logic [31:0]                   in_divisor,
   input  logic [btpc_pkg::DivSideW-1:0] in_side,
   output logic                          out_valid,
   output logic [31:0]                   out_quot,
   output logic [btpc_pkg::DivSideW-1:0] out_side
);

   logic                          valid_s [0:btpc_pkg::DivSteps];
   logic [31:0]                   rem_s   [0:btpc_pkg::DivSteps];
   logic [31:0]                   dvd_s   [0:btpc_pkg::DivSteps];
   logic [31:0]                   dvs_s   [0:btpc_pkg::DivSteps];
   logic [btpc_pkg::DivSideW-1:0] side_s  [0:btpc_pkg::DivSteps];

   assign valid_s[0] = in_valid;
   assign rem_s[0]   = '0;
   assign dvd_s[0]   = in_dividend;
   assign dvs_s[0]   = in_divisor;
   assign side_s[0]  = in_side;

   for (genvar i = 0; i < btpc_pkg::DivSteps; i++) begin : g_step
      logic [32:0]                   rem_sh;
      logic [32:0]                   diff;
      logic                          ge;
      logic [31:0]                   rem_in;
      logic [31:0]                   dvd_in;
      logic                          valid_ff;
      logic [31:0]                   rem_ff;
      logic [31:0]                   dvd_ff;
      logic [31:0]                   dvs_ff;
      logic [btpc_pkg::DivSideW-1:0] side_ff;

      // dividend register shifts out its top bit and takes the quotient bit in
      assign rem_sh = {rem_s[i], dvd_s[i][31]};
      assign diff   = rem_sh - {1'b0, dvs_s[i]};
      assign ge     = !diff[32];
      assign rem_in = ge ? diff[31:0] : rem_sh[31:0];
      assign dvd_in = {dvd_s[i][30:0], ge};

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff <= 1'b0;
         end else if (adv) begin
            valid_ff <= valid_s[i];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff  <= rem_in;
            dvd_ff  <= dvd_in;
            dvs_ff  <= dvs_s[i];
            side_ff <= side_s[i];
         end
      end

      assign valid_s[i+1] = valid_ff;
      assign rem_s[i+1]   = rem_ff;
      assign dvd_s[i+1]   = dvd_ff;
      assign dvs_s[i+1]   = dvs_ff;
      assign side_s[i+1]  = side_ff;
   end

   assign out_valid = valid_s[btpc_pkg::DivSteps];
   assign out_quot  = dvd_s[btpc_pkg::DivSteps];
   assign out_side  = side_s[btpc_pkg::DivSteps];

endmodule

// ----- rtl/btpc_front.sv -----
// Front stages: uncorrected temperature term and operand prep for the first divide.
// Depends on btpc_pkg.
module btpc_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          adv,
   input  btpc_pkg::cfg_type             cfg,
   input  logic                          in_valid,
   input  btpc_pkg::req_type             in_data,
   output logic                          div_valid,
   output logic [31:0]                   div_dividend,
   output logic [31:0]                   div_divisor,
   output logic [btpc_pkg::DivSideW-1:0] div_side
);

   // stage 1: (rt - ac6) * ac5
   logic               v1_ff;
   logic signed [31:0] tdiff;
   logic signed [31:0] p1_in;
   logic signed [31:0] p1_ff;
   logic [18:0]        rp1_ff;

   assign tdiff = signed'({16'b0, in_data.raw_temp}) - signed'({16'b0, cfg.ac6});
   assign p1_in = tdiff * signed'({16'b0, cfg.ac5});

   // stage 2: x1 and the divisor x1 + md
   logic               v2_ff;
   logic signed [31:0] x1_in;
   logic signed [31:0] den_in;
   logic signed [31:0] x1_ff;
   logic signed [31:0] den_ff;
   logic [18:0]        rp2_ff;

   assign x1_in  = p1_ff >>> 15;
   assign den_in = x1_in + btpc_pkg::sext16(cfg.md);

   // stage 3: magnitudes and sign for the unsigned divider
   logic                    v3_ff;
   logic signed [31:0]      num;
   logic [31:0]             dvd_in;
   logic [31:0]             dvs_in;
   btpc_pkg::div1_side_type side_in;
   logic [31:0]             dvd_ff;
   logic [31:0]             dvs_ff;
   btpc_pkg::div1_side_type side_ff;

   assign num    = btpc_pkg::sext16(cfg.mc) <<< 11;
   assign dvd_in = num[31] ? 32'(-num) : 32'(num);
   assign dvs_in = den_ff[31] ? 32'(-den_ff) : 32'(den_ff);
   always_comb begin
      side_in.x1  = x1_ff;
      side_in.rp  = rp2_ff;
      side_in.dz  = (den_ff == 32'sd0);
      side_in.neg = num[31] ^ den_ff[31];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p1_ff   <= p1_in;
         rp1_ff  <= in_data.raw_pressure;
         x1_ff   <= x1_in;
         den_ff  <= den_in;
         rp2_ff  <= rp1_ff;
         dvd_ff  <= dvd_in;
         dvs_ff  <= dvs_in;
         side_ff <= side_in;
      end
   end

   assign div_valid    = v3_ff;
   assign div_dividend = dvd_ff;
   assign div_divisor  = dvs_ff;
   assign div_side     = btpc_pkg::DivSideW'(side_ff);

endmodule

// ----- rtl/btpc_mid.sv -----
// Middle stages: b5, temperature, b3, b4, b7 and operand prep for the pressure divide.
// Depends on btpc_pkg.
module btpc_mid (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          adv,
   input  btpc_pkg::cfg_type             cfg,
   input  logic                          in_valid,
   input  logic [31:0]                   in_quot,
   input  logic [btpc_pkg::DivSideW-1:0] in_side,
   output logic                          div_valid,
   output logic [31:0]                   div_dividend,
   output logic [31:0]                   div_divisor,
   output logic [btpc_pkg::DivSideW-1:0] div_side
);

   typedef struct packed {
      logic [18:0]        rp;
      logic signed [15:0] t;
      logic               dz;
   } carry_type;

   btpc_pkg::div1_side_type s1;
   assign s1 = btpc_pkg::div1_side_type'(in_side);

   // M1: b5
   logic               v1_ff;
   logic signed [31:0] x2;
   logic signed [31:0] b5_in, b5_ff;
   carry_type          c1_in, c1_ff;
   assign x2    = s1.neg ? -signed'(in_quot) : signed'(in_quot);
   assign b5_in = s1.x1 + x2;
   always_comb begin
      c1_in.rp = s1.rp;
      c1_in.t  = '0;
      c1_in.dz = s1.dz;
   end

   // M2: temperature and b6
   logic               v2_ff;
   logic signed [31:0] tt;
   logic signed [31:0] b6_in, b6_ff;
   carry_type          c2_in, c2_ff;
   assign tt    = (b5_ff + 32'sd8) >>> 4;
   assign b6_in = b5_ff - btpc_pkg::B6Offset;
   always_comb begin
      c2_in = c1_ff;
      if (tt > btpc_pkg::TempMax) begin
         c2_in.t = 16'sh7fff;
      end else if (tt < btpc_pkg::TempMin) begin
         c2_in.t = 16'sh8000;
      end else begin
         c2_in.t = tt[15:0];
      end
   end

   // M3: products on b6
   logic               v3_ff;
   logic signed [31:0] mb6_in, mb6_ff, ma2_in, ma2_ff, ma3_in, ma3_ff;
   carry_type          c3_ff;
   assign mb6_in = b6_ff * b6_ff;
   assign ma2_in = btpc_pkg::sext16(cfg.ac2) * b6_ff;
   assign ma3_in = btpc_pkg::sext16(cfg.ac3) * b6_ff;

   // M4: scale
   logic               v4_ff;
   logic signed [31:0] sq_ff, xa2_ff, xa3_ff;
   carry_type          c4_ff;

   // M5: products on sq
   logic               v5_ff;
   logic signed [31:0] mb2_in, mb2_ff, mb1_in, mb1_ff, xa2b_ff, xa3b_ff;
   carry_type          c5_ff;
   assign mb2_in = btpc_pkg::sext16(cfg.b2) * sq_ff;
   assign mb1_in = btpc_pkg::sext16(cfg.b1) * sq_ff;

   // M6: x3 sums
   logic               v6_ff;
   logic signed [31:0] xb3_in, xb3_ff, xp_in, xp_ff;
   carry_type          c6_ff;
   assign xb3_in = btpc_pkg::sdiv_pow2(mb2_ff, 11) + xa2b_ff;
   assign xp_in  = xa3b_ff + btpc_pkg::sdiv_pow2(mb1_ff, 16);

   // M7
   logic               v7_ff;
   logic signed [31:0] sh_in, sh_ff, x3_in, x3_ff;
   carry_type          c7_ff;
   assign sh_in = (btpc_pkg::sext16(cfg.ac1) * 32'sd4 + xb3_ff) << cfg.oss;
   assign x3_in = btpc_pkg::sdiv_pow2(xp_ff + 32'sd2, 2);

   // M8: b3 and b4 operand
   logic               v8_ff;
   logic signed [31:0] b3_in, b3_ff;
   logic [31:0]        cc_in, cc_ff;
   carry_type          c8_ff;
   assign b3_in = btpc_pkg::sdiv_pow2(sh_ff + 32'sd2, 2);
   assign cc_in = 32'(x3_ff) + btpc_pkg::B4Offset;

   // M9: b4 and rp - b3
   logic               v9_ff;
   logic [31:0]        b4_prod, b4_in, b4_ff, d_in, d_ff;
   carry_type          c9_ff;
   assign b4_prod = {16'b0, cfg.ac4} * cc_ff;
   assign b4_in   = b4_prod >> 15;
   assign d_in    = {13'b0, c8_ff.rp} - 32'(b3_ff);

   // M10: b7
   logic               v10_ff;
   logic [31:0]        b7_in, b7_ff, b4b_ff;
   carry_type          c10_ff;
   assign b7_in = d_ff * (btpc_pkg::B7Scale >> cfg.oss);

   // M11: divider operands
   logic                    v11_ff;
   logic [31:0]             dvd_in, dvd_ff, dvs_ff;
   btpc_pkg::div2_side_type side_in, side_ff;
   assign dvd_in = b7_ff[31] ? b7_ff : {b7_ff[30:0], 1'b0};
   always_comb begin
      side_in.dz  = c10_ff.dz;
      side_in.b4z = (b4b_ff == 32'd0);
      side_in.big = b7_ff[31];
      side_in.t   = c10_ff.t;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff  <= 1'b0;
         v2_ff  <= 1'b0;
         v3_ff  <= 1'b0;
         v4_ff  <= 1'b0;
         v5_ff  <= 1'b0;
         v6_ff  <= 1'b0;
         v7_ff  <= 1'b0;
         v8_ff  <= 1'b0;
         v9_ff  <= 1'b0;
         v10_ff <= 1'b0;
         v11_ff <= 1'b0;
      end else if (adv) begin
         v1_ff  <= in_valid;
         v2_ff  <= v1_ff;
         v3_ff  <= v2_ff;
         v4_ff  <= v3_ff;
         v5_ff  <= v4_ff;
         v6_ff  <= v5_ff;
         v7_ff  <= v6_ff;
         v8_ff  <= v7_ff;
         v9_ff  <= v8_ff;
         v10_ff <= v9_ff;
         v11_ff <= v10_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         b5_ff   <= b5_in;
         c1_ff   <= c1_in;
         b6_ff   <= b6_in;
         c2_ff   <= c2_in;
         mb6_ff  <= mb6_in;
         ma2_ff  <= ma2_in;
         ma3_ff  <= ma3_in;
         c3_ff   <= c2_ff;
         sq_ff   <= btpc_pkg::sdiv_pow2(mb6_ff, 12);
         xa2_ff  <= btpc_pkg::sdiv_pow2(ma2_ff, 11);
         xa3_ff  <= btpc_pkg::sdiv_pow2(ma3_ff, 13);
         c4_ff   <= c3_ff;
         mb2_ff  <= mb2_in;
         mb1_ff  <= mb1_in;
         xa2b_ff <= xa2_ff;
         xa3b_ff <= xa3_ff;
         c5_ff   <= c4_ff;
         xb3_ff  <= xb3_in;
         xp_ff   <= xp_in;
         c6_ff   <= c5_ff;
         sh_ff   <= sh_in;
         x3_ff   <= x3_in;
         c7_ff   <= c6_ff;
         b3_ff   <= b3_in;
         cc_ff   <= cc_in;
         c8_ff   <= c7_ff;
         b4_ff   <= b4_in;
         d_ff    <= d_in;
         c9_ff   <= c8_ff;
         b7_ff   <= b7_in;
         b4b_ff  <= b4_ff;
         c10_ff  <= c9_ff;
         dvd_ff  <= dvd_in;
         dvs_ff  <= b4b_ff;
         side_ff <= side_in;
      end
   end

   assign div_valid    = v11_ff;
   assign div_dividend = dvd_ff;
   assign div_divisor  = dvs_ff;
   assign div_side     = btpc_pkg::DivSideW'(side_ff);

endmodule

// ----- rtl/btpc_back.sv -----
// Back stages: pressure quotient, second-order correction and the result register.
// Depends on btpc_pkg.
module btpc_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          adv,
   input  logic                          in_valid,
   input  logic [31:0]                   in_quot,
   input  logic [btpc_pkg::DivSideW-1:0] in_side,
   output logic                          out_valid,
   output btpc_pkg::rsp_type             out_data
);

   typedef struct packed {
      logic signed [15:0] t;
      logic               err;
   } carry_type;

   btpc_pkg::div2_side_type s2;
   assign s2 = btpc_pkg::div2_side_type'(in_side[$bits(btpc_pkg::div2_side_type)-1:0]);

   // B1: p
   logic               v1_ff;
   logic signed [31:0] p_in, p1_ff;
   carry_type          c1_in, c1_ff;
   assign p_in = s2.big ? signed'({in_quot[30:0], 1'b0}) : signed'(in_quot);
   always_comb begin
      c1_in.t   = s2.t;
      c1_in.err = s2.dz | s2.b4z;
   end

   // B2
   logic               v2_ff;
   logic signed [31:0] pd_ff, m7_in, m7_ff, p2_ff;
   carry_type          c2_ff;
   assign m7_in = btpc_pkg::LinCoef * p1_ff;

   // B3
   logic               v3_ff;
   logic signed [31:0] sqp_in, sqp_ff, x2_ff, p3_ff;
   carry_type          c3_ff;
   assign sqp_in = pd_ff * pd_ff;

   // B4
   logic               v4_ff;
   logic signed [31:0] x1b_in, x1b_ff, x2b_ff, p4_ff;
   carry_type          c4_ff;
   assign x1b_in = sqp_ff * btpc_pkg::QuadCoef;

   // B5
   logic               v5_ff;
   logic signed [31:0] s_in, s_ff, p5_ff;
   carry_type          c5_ff;
   assign s_in = btpc_pkg::sdiv_pow2(x1b_ff, 16) + x2b_ff + btpc_pkg::FinalOffs;

   // B6: result register
   logic               v6_ff;
   logic signed [31:0] pf;
   btpc_pkg::rsp_type  rsp_in, rsp_ff;
   assign pf = p5_ff + btpc_pkg::sdiv_pow2(s_ff, 4);
   always_comb begin
      rsp_in.div_error     = c5_ff.err;
      rsp_in.temp_tenths_c = c5_ff.err ? 16'sd0 : c5_ff.t;
      rsp_in.pressure_pa   = c5_ff.err ? 32'sd0 : pf;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p1_ff  <= p_in;
         c1_ff  <= c1_in;
         pd_ff  <= btpc_pkg::sdiv_pow2(p1_ff, 8);
         m7_ff  <= m7_in;
         p2_ff  <= p1_ff;
         c2_ff  <= c1_ff;
         sqp_ff <= sqp_in;
         x2_ff  <= btpc_pkg::sdiv_pow2(m7_ff, 16);
         p3_ff  <= p2_ff;
         c3_ff  <= c2_ff;
         x1b_ff <= x1b_in;
         x2b_ff <= x2_ff;
         p4_ff  <= p3_ff;
         c4_ff  <= c3_ff;
         s_ff   <= s_in;
         p5_ff  <= p4_ff;
         c5_ff  <= c4_ff;
         rsp_ff <= rsp_in;
      end
   end

   assign out_valid = v6_ff;
   assign out_data  = rsp_ff;

endmodule

// ----- rtl/baro_temp_pressure_compensate.sv -----
// Barometer temperature and pressure compensation, fully pipelined.
// Request channel (req_*) takes raw temperature and raw pressure; one transaction
// per cycle is accepted while req_stall is low.
// Response channel (rsp_*) returns temperature in 0.1 degC, pressure in Pa and a
// divide error flag (divisor zero; both values then read zero), one per request,
// in order.
// The path from request to response runs through 3 front stages, two 32-stage
// radix-2 dividers carrying one quotient bit per stage, 11 middle stages and
// 6 back stages, the last being the output register. Throughput is one
// transaction per clock while no response is stalled.
// A stalled response freezes the whole pipeline; req_stall then rises in the same
// cycle, so nothing is dropped or duplicated.
// Calibration and oversampling registers are written through csr_*, by the user
// only while idle; the block does not enforce this. Synchronous reset empties the
// pipeline, zeros calibration and sets oversampling to 1.
// Depends on btpc_pkg, btpc_front, btpc_udiv, btpc_mid, btpc_back and the macro header.
`include "baro_temp_pressure_compensate_macros.svh"

module baro_temp_pressure_compensate (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  btpc_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output btpc_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic [2:0]        csr_index,
   input  logic [31:0]       csr_wdata
);

   btpc_pkg::cfg_type cfg_ff;
   logic              adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{oss: 2'd1, default: '0};
      end else if (csr_we) begin
         unique case (btpc_pkg::csr_index_type'(csr_index))
            btpc_pkg::CSR_AC1:     cfg_ff.ac1 <= csr_wdata[15:0];
            btpc_pkg::CSR_AC2:     cfg_ff.ac2 <= csr_wdata[15:0];
            btpc_pkg::CSR_AC3:     cfg_ff.ac3 <= csr_wdata[15:0];
            btpc_pkg::CSR_AC4_AC5: begin
               cfg_ff.ac4 <= csr_wdata[31:16];
               cfg_ff.ac5 <= csr_wdata[15:0];
            end
            btpc_pkg::CSR_AC6:     cfg_ff.ac6 <= csr_wdata[15:0];
            btpc_pkg::CSR_B1_B2: begin
               cfg_ff.b1 <= csr_wdata[31:16];
               cfg_ff.b2 <= csr_wdata[15:0];
            end
            btpc_pkg::CSR_MC_MD: begin
               cfg_ff.mc <= csr_wdata[31:16];
               cfg_ff.md <= csr_wdata[15:0];
            end
            btpc_pkg::CSR_OSS:     cfg_ff.oss <= csr_wdata[1:0];
            default: ;
         endcase
      end
   end

   // whole pipeline moves unless a finished result is held
   assign adv       = !rsp_valid || !rsp_stall;
   assign req_stall = !adv;

   logic                          d1i_valid, d1o_valid, d2i_valid, d2o_valid;
   logic [31:0]                   d1i_dvd, d1i_dvs, d1o_quot, d2i_dvd, d2i_dvs, d2o_quot;
   logic [btpc_pkg::DivSideW-1:0] d1i_side, d1o_side, d2i_side, d2o_side;

   btpc_front u_front (
      .clock(clock), .reset(reset), .adv(adv), .cfg(cfg_ff),
      .in_valid(req_valid), .in_data(req_data),
      .div_valid(d1i_valid), .div_dividend(d1i_dvd), .div_divisor(d1i_dvs),
      .div_side(d1i_side)
   );

   btpc_udiv u_div_temp (
      .clock(clock), .reset(reset), .adv(adv),
      .in_valid(d1i_valid), .in_dividend(d1i_dvd), .in_divisor(d1i_dvs),
      .in_side(d1i_side),
      .out_valid(d1o_valid), .out_quot(d1o_quot), .out_side(d1o_side)
   );

   btpc_mid u_mid (
      .clock(clock), .reset(reset), .adv(adv), .cfg(cfg_ff),
      .in_valid(d1o_valid), .in_quot(d1o_quot), .in_side(d1o_side),
      .div_valid(d2i_valid), .div_dividend(d2i_dvd), .div_divisor(d2i_dvs),
      .div_side(d2i_side)
   );

   btpc_udiv u_div_press (
      .clock(clock), .reset(reset), .adv(adv),
      .in_valid(d2i_valid), .in_dividend(d2i_dvd), .in_divisor(d2i_dvs),
      .in_side(d2i_side),
      .out_valid(d2o_valid), .out_quot(d2o_quot), .out_side(d2o_side)
   );

   btpc_back u_back (
      .clock(clock), .reset(reset), .adv(adv),
      .in_valid(d2o_valid), .in_quot(d2o_quot), .in_side(d2o_side),
      .out_valid(rsp_valid), .out_data(rsp_data)
   );

   `BTPC_ASSERT_IMPLY(a_err_zero, clock, reset, rsp_valid && rsp_data.div_error, rsp_data.pressure_pa == 32'sd0 && rsp_data.temp_tenths_c == 16'sd0)
   `BTPC_ASSERT_IMPLY(a_no_accept_held, clock, reset, rsp_valid && rsp_stall, !(req_valid && !req_stall))
   `BTPC_ASSERT_IMPLY(a_empty_after_reset, clock, reset, $past(reset), !rsp_valid)

endmodule

// ----- bench/baro_temp_pressure_compensate_test.sv -----
// Self-checking testbench for the barometer temperature and pressure compensation block.
// Depends on btpc_pkg and baro_temp_pressure_compensate; predicts each response in-bench.
`timescale 1ns / 100ps

module baro_temp_pressure_compensate_test;
   import btpc_pkg::*;

   localparam int Latency = 84;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_stall;
   req_type       req_data = '0;
   logic          rsp_valid;
   logic          rsp_stall = 1'b0;
   rsp_type       rsp_data;
   logic          csr_we = 1'b0;
   logic [2:0]    csr_index = '0;
   logic [31:0]   csr_wdata = '0;

   baro_temp_pressure_compensate u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // calibration copy used by the predictor
   logic [15:0] k_ac1, k_ac2, k_ac3, k_ac4, k_ac5, k_ac6, k_b1, k_b2, k_mc, k_md;
   logic [1:0]  k_oss;

   req_type     pending_reqs[$];
   rsp_type     expected_rsps[$];
   int          mismatch_count = 0;
   int          rsp_count = 0;
   int          div_error_count = 0;
   int          sent_count = 0;
   bit          quiet = 1'b0;     // no idling near the end
   int          hold_cycles = 0;  // long receiver hold-off, counted by the stall process
   bit          req_taken = 1'b0; // driven transaction accepted at the last rising edge

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      #50_000_000;
      $display("Regression FAIL");
      $finish;
   end

   function automatic logic signed [31:0] tdiv(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
      if (a == 32'sh8000_0000 && b == -32'sd1) return a;
      return a / b;
   endfunction

   function automatic logic signed [31:0] sra(input logic signed [31:0] v, input int n);
      return v >>> n;
   endfunction

   function automatic rsp_type compensate(input req_type r);
      rsp_type o;
      logic signed [31:0] ac1, ac2, ac3, ac5, ac6, b1, b2, mc, md, rt, rp;
      logic signed [31:0] x1, x2, x3, b3, b5, b6, t, p, den, sq;
      logic [31:0] b4, b7, q;
      ac1 = {{16{k_ac1[15]}}, k_ac1};
      ac2 = {{16{k_ac2[15]}}, k_ac2};
      ac3 = {{16{k_ac3[15]}}, k_ac3};
      ac5 = {16'd0, k_ac5};
      ac6 = {16'd0, k_ac6};
      b1 = {{16{k_b1[15]}}, k_b1};
      b2 = {{16{k_b2[15]}}, k_b2};
      mc = {{16{k_mc[15]}}, k_mc};
      md = {{16{k_md[15]}}, k_md};
      rt = {16'd0, r.raw_temp};
      rp = {13'd0, r.raw_pressure};
      o = '0;
      x1 = sra((rt - ac6) * ac5, 15);
      den = x1 + md;
      if (den == 0) begin
         o.div_error = 1'b1;
         return o;
      end
      x2 = tdiv(mc * 2048, den);
      b5 = x1 + x2;
      t = sra(b5 + 8, 4);
      if (t > 32767) t = 32767;
      if (t < -32768) t = -32768;
      b6 = b5 - 4000;
      sq = tdiv(b6 * b6, 4096);
      x1 = tdiv(b2 * sq, 2048);
      x2 = tdiv(ac2 * b6, 2048);
      x3 = x1 + x2;
      b3 = tdiv(((ac1 * 4 + x3) << k_oss) + 2, 4);
      x1 = tdiv(ac3 * b6, 8192);
      x2 = tdiv(b1 * sq, 65536);
      x3 = tdiv(x1 + x2 + 2, 4);
      b4 = ({16'd0, k_ac4} * (32'(x3) + 32'd32768)) >> 15;
      b7 = (32'(rp) - 32'(b3)) * (32'd50000 >> k_oss);
      if (b4 == 0) begin
         o.div_error = 1'b1;
         return o;
      end
      if (b7 < 32'h8000_0000) q = (b7 * 2) / b4;
      else q = (b7 / b4) * 2;
      p = signed'(q);
      x1 = tdiv(p, 256) * tdiv(p, 256);
      x1 = tdiv(x1 * 3038, 65536);
      x2 = tdiv(-32'sd7357 * p, 65536);
      p = p + tdiv(x1 + x2 + 3791, 16);
      o.temp_tenths_c = t[15:0];
      o.pressure_pa = p;
      return o;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch #%0d at %0t: %s got %h expected %h", mismatch_count + 1, $realtime,
               what, got, want);
      mismatch_count++;
   endtask

   // driver: one transaction per accepted handshake, random gaps
   int gap = 0;
   always @(negedge clock) begin
      if (!reset) begin
         if (req_valid && !req_taken) begin
            // hold payload
         end else begin
            if (req_valid) sent_count++;
            if (gap > 0) begin
               gap--;
               req_valid <= 1'b0;
            end else if (pending_reqs.size() > 0 && !(!quiet && $urandom_range(0, 19) == 0)) begin
               req_data <= pending_reqs.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
               if (!quiet && pending_reqs.size() > 0) gap = $urandom_range(1, 14);
            end
         end
      end
   end

   // predictor hooks on accepted requests
   always @(posedge clock) begin
      req_taken = !reset && req_valid && !req_stall;
      if (req_taken) expected_rsps.push_back(compensate(req_data));
   end

   // receiver stall generation
   int rsp_burst = 0;
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles--;
         rsp_stall <= 1'b1;
      end else if (rsp_burst > 0) begin
         rsp_burst--;
         rsp_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 24) == 0) begin
         rsp_burst = $urandom_range(0, 13);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // monitor
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsps.size() == 0) begin
            report_mismatch("unexpected response", 32'(rsp_data.pressure_pa), 32'd0);
         end else begin
            want = expected_rsps.pop_front();
            rsp_count++;
            if (rsp_data.div_error) div_error_count++;
            if (rsp_data.div_error !== want.div_error)
               report_mismatch("div_error", 32'(rsp_data.div_error), 32'(want.div_error));
            if (rsp_data.temp_tenths_c !== want.temp_tenths_c)
               report_mismatch("temp_tenths_c", 32'(rsp_data.temp_tenths_c),
                               32'(want.temp_tenths_c));
            if (rsp_data.pressure_pa !== want.pressure_pa)
               report_mismatch("pressure_pa", rsp_data.pressure_pa, want.pressure_pa);
         end
      end
   end

   task automatic write_csr(input csr_index_type idx, input logic [31:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_AC1:     k_ac1 = val[15:0];
         CSR_AC2:     k_ac2 = val[15:0];
         CSR_AC3:     k_ac3 = val[15:0];
         CSR_AC4_AC5: {k_ac4, k_ac5} = val;
         CSR_AC6:     k_ac6 = val[15:0];
         CSR_B1_B2:   {k_b1, k_b2} = val;
         CSR_MC_MD:   {k_mc, k_md} = val;
         CSR_OSS:     k_oss = val[1:0];
         default:     ;
      endcase
   endtask

   task automatic drain_pipe();
      while (pending_reqs.size() > 0 || req_valid || expected_rsps.size() > 0)
         @(posedge clock);
      repeat (Latency + 4) @(posedge clock);
   endtask

   function automatic req_type make_req(input logic [15:0] t, input logic [18:0] p);
      req_type r;
      r.raw_temp = t;
      r.raw_pressure = p;
      return r;
   endfunction

   // realistic calibration: a typical sensor's words with some jitter
   task automatic typical_cal(input bit jitter);
      write_csr(CSR_AC1, 32'(16'(408 + (jitter ? $urandom_range(0, 400) - 200 : 0))));
      write_csr(CSR_AC2, 32'(16'(-72)));
      write_csr(CSR_AC3, 32'(16'(-14383)));
      write_csr(CSR_AC4_AC5, {16'd32741, 16'(32757 - (jitter ? $urandom_range(0, 8000) : 0))});
      write_csr(CSR_AC6, 32'(16'd23153 + (jitter ? $urandom_range(0, 2000) : 0)));
      write_csr(CSR_B1_B2, {16'd6190, 16'd4});
      write_csr(CSR_MC_MD, {16'(-8711), 16'(2868)});
   endtask

   task automatic random_reqs(input int n);
      repeat (n) begin
         case ($urandom_range(0, 3))
            0: pending_reqs.push_back(make_req(16'($urandom), 19'($urandom)));
            default: pending_reqs.push_back(make_req(16'($urandom_range(20000, 32000)),
                                                     19'($urandom_range(20000, 120000))));
         endcase
      end
   endtask

   initial begin
      int phase;
      k_ac1 = 0; k_ac2 = 0; k_ac3 = 0; k_ac4 = 0; k_ac5 = 0; k_ac6 = 0;
      k_b1 = 0; k_b2 = 0; k_mc = 0; k_md = 0; k_oss = 2'd1;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset calibration: every item divides by zero
      pending_reqs.push_back(make_req(16'd0, 19'd0));
      pending_reqs.push_back(make_req(16'hFFFF, 19'h7FFFF));
      drain_pipe();

      // directed: typical calibration, field extremes, every oversampling mode
      typical_cal(1'b0);
      for (int m = 0; m < 4; m++) begin
         write_csr(CSR_OSS, 32'(m));
         pending_reqs.push_back(make_req(16'd27898, 19'(23843 << m)));
         pending_reqs.push_back(make_req(16'd0, 19'd0));
         pending_reqs.push_back(make_req(16'hFFFF, 19'h7FFFF));
         pending_reqs.push_back(make_req(16'h8000, 19'h40000));
         drain_pipe();
      end
      // temperature divisor zero: md cancels x1 (ac5 = 0 gives x1 = 0, md = 0)
      write_csr(CSR_AC4_AC5, {16'd32741, 16'd0});
      write_csr(CSR_MC_MD, {16'h7FFF, 16'd0});
      pending_reqs.push_back(make_req(16'd1234, 19'd5000));
      drain_pipe();
      // saturated temperature: huge mc over md = 1
      write_csr(CSR_MC_MD, {16'h7FFF, 16'd1});
      pending_reqs.push_back(make_req(16'd1234, 19'd5000));
      drain_pipe();
      write_csr(CSR_MC_MD, {16'h8000, 16'd1});
      pending_reqs.push_back(make_req(16'd1234, 19'd5000));
      drain_pipe();
      // b4 zero: ac4 = 0
      write_csr(CSR_AC4_AC5, {16'd0, 16'd32757});
      pending_reqs.push_back(make_req(16'd27898, 19'd23843));
      drain_pipe();
      // extreme calibration words
      write_csr(CSR_AC1, 32'h8000);
      write_csr(CSR_AC2, 32'h7FFF);
      write_csr(CSR_AC3, 32'h8000);
      write_csr(CSR_AC4_AC5, 32'hFFFF_FFFF);
      write_csr(CSR_AC6, 32'hFFFF);
      write_csr(CSR_B1_B2, 32'h7FFF_8000);
      write_csr(CSR_MC_MD, 32'h8000_7FFF);
      write_csr(CSR_OSS, 32'd3);
      pending_reqs.push_back(make_req(16'd0, 19'd0));
      pending_reqs.push_back(make_req(16'hFFFF, 19'h7FFFF));
      pending_reqs.push_back(make_req(16'h5555, 19'h2AAAA));
      drain_pipe();

      // random phases: mostly realistic calibration, some fully random
      for (phase = 0; phase < 12; phase++) begin
         if (phase % 4 == 3) begin
            write_csr(CSR_AC1, $urandom);
            write_csr(CSR_AC2, $urandom);
            write_csr(CSR_AC3, $urandom);
            write_csr(CSR_AC4_AC5, $urandom);
            write_csr(CSR_AC6, $urandom);
            write_csr(CSR_B1_B2, $urandom);
            write_csr(CSR_MC_MD, $urandom);
         end else begin
            typical_cal(1'b1);
         end
         write_csr(CSR_OSS, 32'($urandom_range(0, 3)));
         if (phase == 5) begin
            random_reqs(160);
            hold_cycles = 300;  // receiver holds off; pipeline fills and stalls input
         end else begin
            random_reqs(150);
         end
         if (phase == 11) quiet = 1'b1;
         drain_pipe();
      end

      $display("Covered %0d transactions sent, %0d responses checked, %0d divide errors,",
               sent_count, rsp_count, div_error_count);
      $display("all four oversampling modes, extreme and typical calibration words.");
      if (mismatch_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
